### hdl/aps_pkg.sv
package aps_pkg;

  // Field widths of the item formats
  localparam int SlotW    = 4;
  localparam int TimeW    = 16;
  localparam int PriW     = 16;
  localparam int StepW    = 8;
  localparam int CfgIdxW  = 2;

  // Default number of task slots
  localparam int NumSlotsDef = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgStartedStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFreshStep   = 2'd1;

  // Input function codes
  localparam logic FuncAdmit = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // Reset values of the step registers
  localparam logic [StepW-1:0] StartedStepRst = 8'd1;
  localparam logic [StepW-1:0] FreshStepRst   = 8'd2;

  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [PriW-1:0]  PriMax  = '1;

  typedef enum logic [1:0] {
    SL_EMPTY   = 2'd0,
    SL_STARTED = 2'd1,
    SL_FRESH   = 2'd2,
    SL_DONE    = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN,
    CS_SCAN_END,
    CS_DECIDE,
    CS_UPDATE,
    CS_UPD_END,
    CS_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic             func;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0] ran_slot;
    logic             idle;
    logic             finished;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [PriW-1:0]  final_priority;
  } out_item_t;

  // One slot record as held in the slot RAM
  typedef struct packed {
    logic [PriW-1:0]  prio;
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] service_total;
    logic [TimeW-1:0] admit_time;
  } slot_rec_t;

  // Controller to datapath
  typedef struct packed {
    logic admit;       // write an admitted task
    logic tick_start;  // clear search and result state
    logic rd_en;       // read the next slot record
    logic upd;         // the read feeds the update pass, else the search pass
    logic load_out;    // load the output register, advance time
  } aps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;    // the read issued now is the last slot
    logic found;       // a ready slot was found
    logic out_free;    // output register can take a beat
  } aps_stat_t;

endpackage

### hdl/aps_ram.sv
module aps_ram #(
  parameter int Width = 64,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/aps_ctrl.sv
module aps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  output logic              in_stall_o,
  input  aps_pkg::aps_stat_t stat_i,
  output aps_pkg::aps_cmd_t  cmd_o
);
  import aps_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        take;

  assign take = in_valid_i && (state_q == CS_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (take && in_func_i == FuncTick) begin
          state_d = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (stat_i.cnt_last) begin
          state_d = CS_SCAN_END;
        end
      end
      CS_SCAN_END: state_d = CS_DECIDE;
      CS_DECIDE: begin
        state_d = stat_i.found ? CS_UPDATE : CS_RESULT;
      end
      CS_UPDATE: begin
        if (stat_i.cnt_last) begin
          state_d = CS_UPD_END;
        end
      end
      CS_UPD_END: state_d = CS_RESULT;
      CS_RESULT: begin
        if (stat_i.out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != CS_IDLE);
    case (state_q)
      CS_IDLE: begin
        cmd_o.admit      = take && (in_func_i == FuncAdmit);
        cmd_o.tick_start = take && (in_func_i == FuncTick);
      end
      CS_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      CS_UPDATE: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.upd   = 1'b1;
      end
      CS_RESULT: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/aps_dp.sv
module aps_dp #(
  parameter int NumSlots = aps_pkg::NumSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aps_pkg::in_item_t           in_item_i,
  input  aps_pkg::aps_cmd_t           cmd_i,
  output aps_pkg::aps_stat_t          stat_o,
  input  logic                        cfg_valid_i,
  input  logic [aps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aps_pkg::StepW-1:0]   cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output aps_pkg::out_item_t          out_item_o
);
  import aps_pkg::*;

  localparam int IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int RecW = $bits(slot_rec_t);

  function automatic logic [PriW-1:0] sat_add(input logic [PriW-1:0] a,
                                              input logic [StepW-1:0] b);
    logic [PriW:0] s;
    s = {1'b0, a} + {{(PriW + 1 - StepW){1'b0}}, b};
    return s[PriW] ? PriMax : s[PriW-1:0];
  endfunction

  // Configuration and time
  logic [StepW-1:0] started_step_q, started_step_d;
  logic [StepW-1:0] fresh_step_q, fresh_step_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [TimeW-1:0] fin_time;

  // Slot states, record RAM walk
  slot_state_e      status_q [NumSlots];
  slot_state_e      status_d [NumSlots];
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic             cnt_last;
  logic             pend_q;
  logic             pend_upd_q;
  logic [IdxW-1:0]  pend_idx_q;
  slot_state_e      pend_state;
  logic             pend_ready;

  // Search and result
  logic             found_q, found_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [PriW-1:0]  best_pri_q, best_pri_d;
  logic             res_fin_q, res_fin_d;
  logic [TimeW-1:0] res_ta_q, res_ta_d;
  logic [TimeW-1:0] res_svc_q, res_svc_d;
  logic [PriW-1:0]  res_pri_q, res_pri_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  // RAM port signals
  logic             admit_ok;
  logic [IdxW-1:0]  adm_idx;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  slot_rec_t        ram_wrec;
  slot_rec_t        rd_rec;
  slot_rec_t        upd_rec;
  logic [RecW-1:0]  ram_rdata;

  aps_ram #(
    .Width (RecW),
    .Depth (NumSlots)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wrec),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  assign rd_rec     = slot_rec_t'(ram_rdata);
  assign cnt_last   = (cnt_q == IdxW'(NumSlots - 1));
  assign pend_state = status_q[pend_idx_q];
  assign pend_ready = (pend_state == SL_STARTED) || (pend_state == SL_FRESH);
  assign fin_time   = (now_q == TimeMax) ? now_q : now_q + 1'b1;
  assign admit_ok   = cmd_i.admit && (32'(in_item_i.slot) < NumSlots);
  assign adm_idx    = IdxW'(in_item_i.slot);

  // Read address walk over all slots
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.rd_en) begin
      cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
    end
  end

  // Search pass: highest priority, lowest slot on ties
  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_pri_d = best_pri_q;
    if (cmd_i.tick_start) begin
      found_d = 1'b0;
    end else if (pend_q && !pend_upd_q && pend_ready &&
                 (!found_q || rd_rec.prio > best_pri_q)) begin
      found_d    = 1'b1;
      best_idx_d = pend_idx_q;
      best_pri_d = rd_rec.prio;
    end
  end

  // Update pass: serve the chosen slot, age the other ready slots
  always_comb begin
    upd_rec   = rd_rec;
    status_d  = status_q;
    res_fin_d = res_fin_q;
    res_ta_d  = res_ta_q;
    res_svc_d = res_svc_q;
    res_pri_d = res_pri_q;
    if (cmd_i.tick_start) begin
      res_fin_d = 1'b0;
    end
    if (admit_ok) begin
      status_d[adm_idx] = SL_FRESH;
    end
    if (pend_q && pend_upd_q) begin
      if (found_q && pend_idx_q == best_idx_q) begin
        if (rd_rec.remaining <= TimeW'(1)) begin
          upd_rec.remaining    = '0;
          status_d[pend_idx_q] = SL_DONE;
          res_fin_d            = 1'b1;
          res_ta_d             = fin_time - rd_rec.admit_time;
          res_svc_d            = rd_rec.service_total;
          res_pri_d            = rd_rec.prio;
        end else begin
          upd_rec.remaining    = rd_rec.remaining - 1'b1;
          status_d[pend_idx_q] = SL_STARTED;
        end
      end else if (pend_state == SL_STARTED) begin
        upd_rec.prio = sat_add(rd_rec.prio, started_step_q);
      end else if (pend_state == SL_FRESH) begin
        upd_rec.prio = sat_add(rd_rec.prio, fresh_step_q);
      end
    end
  end

  // RAM write: admit in idle, write-back during the update pass
  always_comb begin
    ram_we    = admit_ok || (pend_q && pend_upd_q);
    ram_waddr = pend_idx_q;
    ram_wrec  = upd_rec;
    if (admit_ok) begin
      ram_waddr              = adm_idx;
      ram_wrec.prio          = '0;
      ram_wrec.remaining     = in_item_i.service_time;
      ram_wrec.service_total = in_item_i.service_time;
      ram_wrec.admit_time    = now_q;
    end
  end

  // Config writes, unknown indexes ignored
  always_comb begin
    started_step_d = started_step_q;
    fresh_step_d   = fresh_step_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStartedStep: started_step_d = cfg_data_i;
        CfgFreshStep:   fresh_step_d   = cfg_data_i;
        default: begin
          started_step_d = started_step_q;
        end
      endcase
    end
  end

  // Output register and time step
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    now_d       = now_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      now_d       = fin_time;
      out_item_d  = '0;
      out_item_d.idle = !found_q;
      if (found_q) begin
        out_item_d.ran_slot = SlotW'(best_idx_q);
      end
      if (res_fin_q) begin
        out_item_d.finished       = 1'b1;
        out_item_d.turnaround     = res_ta_q;
        out_item_d.waiting        = (res_ta_q > res_svc_q) ? res_ta_q - res_svc_q : '0;
        out_item_d.final_priority = res_pri_q;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_step_q <= StartedStepRst;
      fresh_step_q   <= FreshStepRst;
      now_q          <= '0;
      cnt_q          <= '0;
      pend_q         <= 1'b0;
      pend_upd_q     <= 1'b0;
      found_q        <= 1'b0;
      res_fin_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        status_q[i] <= SL_EMPTY;
      end
    end else begin
      started_step_q <= started_step_d;
      fresh_step_q   <= fresh_step_d;
      now_q          <= now_d;
      cnt_q          <= cnt_d;
      pend_q         <= cmd_i.rd_en;
      pend_upd_q     <= cmd_i.upd;
      found_q        <= found_d;
      res_fin_q      <= res_fin_d;
      out_valid_q    <= out_valid_d;
      status_q       <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= cnt_q;
    best_idx_q <= best_idx_d;
    best_pri_q <= best_pri_d;
    res_ta_q   <= res_ta_d;
    res_svc_q  <= res_svc_d;
    res_pri_q  <= res_pri_d;
    out_item_q <= out_item_d;
  end

  assign stat_o.cnt_last = cnt_last;
  assign stat_o.found    = found_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;

`ifndef SYNTHESIS
  // a finished result always comes from a served slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && res_fin_q) |-> found_q)
    else $error("finished result without a served slot");

  // admits never collide with the write-back pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.admit && pend_q))
    else $error("admit during slot walk");

  // output register is only loaded when it can take the beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");

  // time never runs backward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q))
    else $error("time counter decreased");
`endif

endmodule

### hdl/aging_priority_scheduler_top.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o  in_item_i (func, slot, service_time)
// out       output     out_valid_o/out_stall_i out_item_o (ran_slot .. final_priority)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An admit beat is written as it is taken. A tick beat walks the slot record RAM for a
// search pass, then an update pass if a slot is served, and then loads its result.
// One beat is worked at a time; the next beat is taken while a result waits.
// Reset empties all slots, zeroes time and loads the default steps; no clearing pass.
// A stalled output holds its beat; a tick result waits in place while the output stalls.
module aging_priority_scheduler_top #(
  parameter int NUM_SLOTS = aps_pkg::NumSlotsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  aps_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output aps_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [aps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aps_pkg::StepW-1:0]   cfg_data_i
);
  import aps_pkg::*;

  aps_cmd_t  cmd;
  aps_stat_t stat;

  // Config writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  aps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_item_i.func),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aps_dp #(
    .NumSlots (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### dv/aging_priority_scheduler_top_test.sv
module aging_priority_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aps_pkg::*;

  localparam int NumSlots     = NumSlotsDef;
  localparam int TickCycles   = 2 * NumSlots + 5;
  localparam int SettleCycles = 2 * TickCycles;
  localparam int CycleLimit   = 1_000_000;
  localparam int MaxReports   = 10;

  // DUT connections, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  in_item_t            in_beat     = '0;
  logic                out_valid_o;
  logic                out_stall   = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [StepW-1:0]    cfg_data    = '0;

  // Scheduler image kept by the testbench
  slot_state_e         task_state  [NumSlots];
  logic [PriW-1:0]     task_prio   [NumSlots];
  logic [TimeW-1:0]    task_left   [NumSlots];
  logic [TimeW-1:0]    task_svc    [NumSlots];
  logic [TimeW-1:0]    task_born   [NumSlots];
  logic [TimeW-1:0]    sched_now;
  logic [StepW-1:0]    started_gain;
  logic [StepW-1:0]    fresh_gain;

  in_item_t            in_backlog [$];
  out_item_t           tick_grants [$];
  int unsigned         cycle_cnt   = 0;
  int unsigned         fail_cnt    = 0;
  int unsigned         mismatch_cnt = 0;
  logic                quiet;

  aging_priority_scheduler_top #(
    .NUM_SLOTS (NumSlots)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // No idling on either side inside this window
  assign quiet = (cycle_cnt >= 6000) && (cycle_cnt < 20000);

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? TimeMax : s[15:0];
  endfunction

  // Advance the scheduler image by one input beat
  function automatic void schedule_beat(in_item_t b);
    out_item_t  r;
    int         best;
    logic [15:0] fin;
    logic [15:0] ta;
    best = -1;
    r    = '0;
    if (b.func == FuncAdmit) begin
      task_state[b.slot] = SL_FRESH;
      task_prio[b.slot]  = '0;
      task_left[b.slot]  = b.service_time;
      task_svc[b.slot]   = b.service_time;
      task_born[b.slot]  = sched_now;
      return;
    end
    // highest priority ready slot, lowest index on ties
    for (int s = 0; s < NumSlots; s++) begin
      if (task_state[s] == SL_STARTED || task_state[s] == SL_FRESH) begin
        if (best < 0 || task_prio[s] > task_prio[best]) best = s;
      end
    end
    fin = sat_add(sched_now, 16'd1);
    if (best < 0) begin
      r.idle = 1'b1;
    end else begin
      r.ran_slot = best[SlotW-1:0];
      // age everyone ready except the served task
      for (int s = 0; s < NumSlots; s++) begin
        if (s != best) begin
          if (task_state[s] == SL_STARTED)
            task_prio[s] = sat_add(task_prio[s], {8'd0, started_gain});
          else if (task_state[s] == SL_FRESH)
            task_prio[s] = sat_add(task_prio[s], {8'd0, fresh_gain});
        end
      end
      if (task_left[best] <= 16'd1) begin
        ta               = fin - task_born[best];
        r.finished       = 1'b1;
        r.turnaround     = ta;
        r.waiting        = (ta > task_svc[best]) ? ta - task_svc[best] : '0;
        r.final_priority = task_prio[best];
        task_left[best]  = '0;
        task_state[best] = SL_DONE;
      end else begin
        task_left[best]  = task_left[best] - 16'd1;
        task_state[best] = SL_STARTED;
      end
    end
    sched_now = fin;
    tick_grants.push_back(r);
  endfunction

  // Random beat: mostly ticks, admits with mostly short service
  function automatic in_item_t rand_beat();
    in_item_t    b;
    int unsigned pick;
    b    = '0;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 65) begin
      b.func = FuncTick;
      b.slot = SlotW'($urandom_range(15));
    end else begin
      b.func = FuncAdmit;
      b.slot = SlotW'($urandom_range(NumSlots - 1));
      if (pick < 8)       b.service_time = '0;
      else if (pick < 12) b.service_time = TimeMax;
      else if (pick < 20) b.service_time = TimeW'($urandom_range(65535));
      else                b.service_time = TimeW'($urandom_range(12, 1));
    end
    return b;
  endfunction

  task automatic push_admit(int unsigned slot, int unsigned svc);
    in_item_t b;
    b              = '0;
    b.func         = FuncAdmit;
    b.slot         = slot[SlotW-1:0];
    b.service_time = svc[TimeW-1:0];
    in_backlog.push_back(b);
  endtask

  task automatic push_ticks(int unsigned n);
    in_item_t b;
    b      = '0;
    b.func = FuncTick;
    repeat (n) in_backlog.push_back(b);
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) in_backlog.push_back(rand_beat());
  endtask

  // Wait for all beats and results, then let any admit settle
  task automatic drain();
    do @(posedge clk_i);
    while (in_backlog.size() != 0 || in_valid || tick_grants.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [StepW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CfgStartedStep: started_gain = data;
      CfgFreshStep:   fresh_gain   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_steps(logic [StepW-1:0] started, logic [StepW-1:0] fresh);
    write_reg(CfgStartedStep, started);
    write_reg(CfgFreshStep, fresh);
  endtask

  // Cycle count and run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("** aging_priority_scheduler_top: FAILED **");
      $finish;
    end
  end

  // Input driver: predicts on each accepted beat, holds stalled payload
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) schedule_beat(in_beat);
      if (!in_valid || !in_stall_o) begin
        if (in_backlog.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
          in_valid <= 1'b1;
          in_beat  <= in_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stall, checks each accepted result beat
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (tick_grants.size() == 0) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("unexpected result beat: %p", out_item_o);
        end else begin
          want = tick_grants.pop_front();
          if (out_item_o.ran_slot       !== want.ran_slot   ||
              out_item_o.idle           !== want.idle       ||
              out_item_o.finished       !== want.finished   ||
              out_item_o.turnaround     !== want.turnaround ||
              out_item_o.waiting        !== want.waiting    ||
              out_item_o.final_priority !== want.final_priority) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
              $display("result mismatch: expected %p actual %p", want, out_item_o);
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 30);
    end
  end

  initial begin
    for (int s = 0; s < NumSlots; s++) begin
      task_state[s] = SL_EMPTY;
      task_prio[s]  = '0;
      task_left[s]  = '0;
      task_svc[s]   = '0;
      task_born[s]  = '0;
    end
    sched_now    = '0;
    started_gain = StartedStepRst;
    fresh_gain   = FreshStepRst;

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: idle tick, lowest-slot tie, zero service, overwrite,
    // longest service and alternating service bits
    push_ticks(1);
    push_admit(0, 1);
    push_admit(15, 3);
    push_admit(7, 0);
    push_ticks(3);
    push_admit(4, 5);
    push_ticks(1);
    push_admit(4, 2);
    push_admit(3, 65535);
    push_admit(9, 16'h5AA5);
    push_admit(10, 16'hA55A);
    push_ticks(6);
    push_admit(15, 1);
    push_ticks(3);
    push_random(100);
    drain();

    // Unused register indexes are ignored, then both steps at zero
    write_reg(CfgIdxW'(2), StepW'($urandom_range(255)));
    write_reg(CfgIdxW'(3), StepW'($urandom_range(255)));
    set_steps(8'd0, 8'd0);
    push_random(120);
    drain();

    // Maximum steps with long tasks: priorities run into saturation
    set_steps(8'd255, 8'd255);
    push_admit(2, 2000);
    push_admit(5, 2000);
    push_admit(9, 2000);
    push_ticks(500);
    drain();

    set_steps(8'd255, 8'd0);
    push_random(130);
    drain();

    set_steps(8'd0, 8'd255);
    push_random(130);
    drain();

    set_steps(StepW'($urandom_range(255)), StepW'($urandom_range(255)));
    push_random(140);
    drain();

    if (fail_cnt == 0 && tick_grants.size() == 0) begin
      $display("** aging_priority_scheduler_top: PASSED **");
    end else begin
      $display("** aging_priority_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
